// ===== rtl/particle_splat_accumulator_defines.svh =====
// ============================================================================
// Particle splat accumulator assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef PARTICLE_SPLAT_ACCUMULATOR_DEFINES_SVH
`define PARTICLE_SPLAT_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define PSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// Antecedent implies consequent in the next cycle
`define PSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSA_ASSERT(lbl, clk, rst, prop)
`define PSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/psa_pkg.sv =====
// ============================================================================
// Particle splat accumulator package
// Sizes, command and register codes, arithmetic unit types, exp2 table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

  // Frame geometry
  localparam int IMAGE_WIDTH  = 256;
  localparam int IMAGE_HEIGHT = 256;
  localparam int DOT_SPAN     = 8;
  localparam int HALF_SPAN    = DOT_SPAN / 2;
  localparam int NPIX         = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(NPIX);
  localparam int MAX_DIM      = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int COORD_W      = $clog2(MAX_DIM + 1);
  localparam int PIX_W        = 48;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Border limits on Q.16 pixel coordinates
  localparam longint X_LO = longint'(DOT_SPAN) << 16;
  localparam longint X_HI = longint'(IMAGE_WIDTH - DOT_SPAN) << 16;
  localparam longint Y_LO = longint'(DOT_SPAN) << 16;
  localparam longint Y_HI = longint'(IMAGE_HEIGHT - DOT_SPAN) << 16;

  // Commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SPLAT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EXTENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARPNESS_SQ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MAX      = 3'd4;

  // Fixed-point constants
  localparam logic [39:0] EXP_CAP   = 40'h80_0000_0000;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int          COL_THIRD = 21823;

  // 2^(2^-k) in Q.30
  localparam logic [30:0] POW2_TAB [16] = '{
    31'd1518500250, 31'd1276901415, 31'd1170923763, 31'd1121280436,
    31'd1097253713, 31'd1085434103, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  // Shared arithmetic unit
  localparam logic [1:0] ARITH_MUL  = 2'd0;
  localparam logic [1:0] ARITH_DIV  = 2'd1;
  localparam logic [1:0] ARITH_SQRT = 2'd2;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [55:0] a;
    logic [39:0] b;
  } arith_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

endpackage

`default_nettype wire

// ===== rtl/particle_splat_accumulator.sv =====
// ============================================================================
// Particle splat accumulator
// Velocity-colored dot splatting into a 256x256 RGB Q4.12 frame store.
// ============================================================================
//
// Channel  Signals                                        Handshake
// command  cmd pos_x pos_y vel_x vel_y pixel_index        start & !busy
// result   red_byte green_byte blue_byte                  result_valid, 1 cycle
// config   cfg_index cfg_data                             cfg_valid & cfg_ready
//
// Reset runs a clearing pass over the frame store, one pixel a cycle,
// with busy high; a clear command runs the same pass.
// A read steps through RD0 and RD1, its result strobed in the cycle busy drops.
// A splat runs on one shared multiply/divide/sqrt unit: a setup pass, then
// an x-axis term per column and the rest per pixel (exp2 loops of one
// multiply per set bit, a log2 loop of one multiply per bit, a 40-step
// divide); a body off the frame or too slow ends at the border or speed check.
// Results cannot be stalled; config writes are always ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "particle_splat_accumulator_defines.svh"

module particle_splat_accumulator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       cmd,
  input  wire logic signed [23:0]               pos_x,
  input  wire logic signed [23:0]               pos_y,
  input  wire logic signed [23:0]               vel_x,
  input  wire logic signed [23:0]               vel_y,
  input  wire logic [15:0]                      pixel_index,
  output logic                                  result_valid,
  output logic [7:0]                            red_byte,
  output logic [7:0]                            green_byte,
  output logic [7:0]                            blue_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [psa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [23:0]                      cfg_data
);

  // Sequencer states
  localparam logic [4:0] ST_SWEEP = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_RD0   = 5'd2;
  localparam logic [4:0] ST_RD1   = 5'd3;
  localparam logic [4:0] ST_PX    = 5'd4;
  localparam logic [4:0] ST_PY    = 5'd5;
  localparam logic [4:0] ST_CHK   = 5'd6;
  localparam logic [4:0] ST_VX    = 5'd7;
  localparam logic [4:0] ST_VY    = 5'd8;
  localparam logic [4:0] ST_SPD   = 5'd9;
  localparam logic [4:0] ST_CMP   = 5'd10;
  localparam logic [4:0] ST_RAT   = 5'd11;
  localparam logic [4:0] ST_VP    = 5'd12;
  localparam logic [4:0] ST_COL   = 5'd13;
  localparam logic [4:0] ST_AXD   = 5'd14;
  localparam logic [4:0] ST_AXT   = 5'd15;
  localparam logic [4:0] ST_AXU   = 5'd16;
  localparam logic [4:0] ST_EXP0  = 5'd17;
  localparam logic [4:0] ST_EXPK  = 5'd18;
  localparam logic [4:0] ST_EXPF  = 5'd19;
  localparam logic [4:0] ST_GEX   = 5'd20;
  localparam logic [4:0] ST_GEY   = 5'd21;
  localparam logic [4:0] ST_LNRM  = 5'd22;
  localparam logic [4:0] ST_LSQ   = 5'd23;
  localparam logic [4:0] ST_LFIN  = 5'd24;
  localparam logic [4:0] ST_WDIV  = 5'd25;
  localparam logic [4:0] ST_CH    = 5'd26;
  localparam logic [4:0] ST_WR    = 5'd27;

  // Configuration
  logic [15:0] inv_extent;
  logic [15:0] sharpness_sq;
  logic [15:0] brightness;
  logic [23:0] vel_min;
  logic [23:0] vel_max;

  // Sequencer control
  logic [4:0]           state;
  logic [4:0]           exp_ret;
  logic                 pend;
  logic                 axis_y;
  logic [3:0]           step;
  logic [1:0]           ch;
  logic                 rd_ok;
  psa_pkg::addr_t       clr;
  psa_pkg::addr_t       maddr;
  psa_pkg::arith_ctl_t  ar_ctl;
  psa_pkg::arith_sts_t  ar_sts;
  logic [63:0]          ar_res;

  // Payload
  logic signed [23:0]   in_px, in_py, in_vx, in_vy;
  logic signed [39:0]   xq, yq;
  logic [47:0]          sq_acc;
  logic [23:0]          speed;
  logic [39:0]          ratio;
  logic [27:0]          vp;
  logic [16:0]          col_r, col_g, col_b;
  psa_pkg::coord_t      ic, jc, i_end, j0, j_end;
  logic [31:0]          d2, tq;
  logic [30:0]          eu;
  logic [31:0]          mant;
  logic [39:0]          ex, eres, nrm;
  logic [5:0]           lb;
  logic [15:0]          frac;
  logic [15:0]          wgt;
  logic [15:0]          acc_r, acc_g, acc_b;

  // Memory
  logic                           mem_we;
  psa_pkg::addr_t                 mem_addr;
  logic [psa_pkg::PIX_W-1:0]      mem_wdata;
  logic [psa_pkg::PIX_W-1:0]      mem_rdata;

  // Combinational helpers
  logic [23:0]          px_mag, py_mag, vx_mag, vy_mag;
  psa_pkg::coord_t      axis_coord;
  logic signed [39:0]   axis_d;
  logic [39:0]          axis_ad;
  logic [40:0]          ssum;
  logic [20:0]          lval;
  logic [22:0]          l3;
  logic [53:0]          eshift;
  logic [16:0]          col_sel;
  logic [15:0]          fld_sel;
  logic [16:0]          ch_sum;
  logic [15:0]          ch_sat;
  logic [31:0]          col_v;
  psa_pkg::coord_t      xp, yp;

  function automatic logic signed [39:0] to_pixel(input logic [39:0] mag, input logic neg,
                                                 input int size);
    logic signed [63:0] p;
    logic signed [63:0] sc;
    p  = neg ? -$signed(64'(mag)) : $signed(64'(mag));
    sc = p * 64'(size);
    return 40'((64'(size) <<< 15) + (sc >>> 17));
  endfunction

  function automatic logic [16:0] clamp_unit(input logic signed [31:0] v);
    if (v < 0) begin
      return 17'd0;
    end else if (v > 32'sd65536) begin
      return 17'd65536;
    end
    return v[16:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [15:0] v);
    logic [19:0] sc;
    sc = 20'(v) * 20'd255;
    return (v >= 16'd4096) ? 8'd255 : sc[19:12];
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Magnitudes, axis distance, log and exp helpers
  always_comb begin
    px_mag     = in_px[23] ? (~in_px + 24'd1) : in_px;
    py_mag     = in_py[23] ? (~in_py + 24'd1) : in_py;
    vx_mag     = in_vx[23] ? (~in_vx + 24'd1) : in_vx;
    vy_mag     = in_vy[23] ? (~in_vy + 24'd1) : in_vy;
    axis_coord = axis_y ? jc : ic;
    axis_d     = $signed(40'({axis_coord, 16'd0})) - (axis_y ? yq : xq);
    axis_ad    = axis_d[39] ? 40'(-axis_d) : 40'(axis_d);
    ssum       = {1'b0, ex} + {1'b0, eres};
    lval       = {5'(lb - 6'd16), frac};
    l3         = {2'b00, lval} + {1'b0, lval, 1'b0};
    eshift     = 54'(mant[30:0]) << eu[20:16];
    xp         = xq[16 +: psa_pkg::COORD_W];
    yp         = yq[16 +: psa_pkg::COORD_W];
    col_v      = {4'd0, vp};
  end

  // Channel select for the accumulate loop
  always_comb begin
    case (ch)
      2'd0: begin
        col_sel = col_r;
        fld_sel = mem_rdata[15:0];
      end
      2'd1: begin
        col_sel = col_g;
        fld_sel = mem_rdata[31:16];
      end
      default: begin
        col_sel = col_b;
        fld_sel = mem_rdata[47:32];
      end
    endcase
    ch_sum = {1'b0, fld_sel} + {1'b0, ar_res[31:16]};
    ch_sat = ch_sum[16] ? 16'hFFFF : ch_sum[15:0];
  end

  // Memory port
  always_comb begin
    mem_we    = (state == ST_SWEEP) || (state == ST_WR);
    mem_addr  = (state == ST_SWEEP) ? clr : maddr;
    mem_wdata = (state == ST_SWEEP) ? '0 : {acc_b, acc_g, acc_r};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_extent   <= 16'd7490;
      sharpness_sq <= 16'd4096;
      brightness   <= 16'd4096;
      vel_min      <= 24'd6554;
      vel_max      <= 24'd262144;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psa_pkg::REG_INV_EXTENT:   inv_extent   <= cfg_data[15:0];
        psa_pkg::REG_SHARPNESS_SQ: sharpness_sq <= cfg_data[15:0];
        psa_pkg::REG_BRIGHTNESS:   brightness   <= cfg_data[15:0];
        psa_pkg::REG_VEL_MIN:      vel_min      <= cfg_data;
        psa_pkg::REG_VEL_MAX:      vel_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      clr           <= '0;
      pend          <= 1'b0;
      ar_ctl.start  <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      ar_ctl.start <= 1'b0;
      result_valid <= 1'b0;
      unique case (state)
        ST_SWEEP: begin
          clr <= clr + psa_pkg::addr_t'(1);
          if (clr == psa_pkg::addr_t'(psa_pkg::NPIX - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            in_px <= pos_x;
            in_py <= pos_y;
            in_vx <= vel_x;
            in_vy <= vel_y;
            case (cmd)
              psa_pkg::CMD_CLEAR: begin
                clr   <= '0;
                state <= ST_SWEEP;
              end
              psa_pkg::CMD_SPLAT: state <= ST_PX;
              psa_pkg::CMD_READ: begin
                maddr <= psa_pkg::addr_t'(pixel_index);
                rd_ok <= int'(pixel_index) < psa_pkg::NPIX;
                state <= ST_RD0;
              end
              default: ;
            endcase
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          result_valid <= 1'b1;
          red_byte     <= rd_ok ? to_byte(mem_rdata[15:0])  : 8'd0;
          green_byte   <= rd_ok ? to_byte(mem_rdata[31:16]) : 8'd0;
          blue_byte    <= rd_ok ? to_byte(mem_rdata[47:32]) : 8'd0;
          state        <= ST_IDLE;
        end
        // Pixel mapping
        ST_PX: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(px_mag), b: 40'(inv_extent)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            xq    <= to_pixel(ar_res[39:0], in_px[23], psa_pkg::IMAGE_WIDTH);
            state <= ST_PY;
          end
        end
        ST_PY: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(py_mag), b: 40'(inv_extent)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            yq    <= to_pixel(ar_res[39:0], in_py[23], psa_pkg::IMAGE_HEIGHT);
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (xq > $signed(40'(psa_pkg::X_LO)) && xq < $signed(40'(psa_pkg::X_HI)) &&
              yq > $signed(40'(psa_pkg::Y_LO)) && yq < $signed(40'(psa_pkg::Y_HI))) begin
            state <= ST_VX;
          end else begin
            state <= ST_IDLE;
          end
        end
        // Speed
        ST_VX: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(vx_mag), b: 40'(vx_mag)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend   <= 1'b0;
            sq_acc <= ar_res[47:0];
            state  <= ST_VY;
          end
        end
        ST_VY: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(vy_mag), b: 40'(vy_mag)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend   <= 1'b0;
            sq_acc <= sq_acc + ar_res[47:0];
            state  <= ST_SPD;
          end
        end
        ST_SPD: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_SQRT, a: 56'(sq_acc), b: '0};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            speed <= ar_res[23:0];
            state <= ST_CMP;
          end
        end
        ST_CMP: state <= (speed < vel_min) ? ST_IDLE : ST_RAT;
        // Color ramp
        ST_RAT: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_DIV,
                        a: 56'({speed - vel_min, 16'd0}),
                        b: (vel_max == 24'd0) ? 40'd1 : 40'(vel_max)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            ratio <= ar_res[39:0];
            state <= ST_VP;
          end
        end
        ST_VP: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_SQRT, a: {ratio, 16'd0}, b: '0};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            vp    <= ar_res[27:0];
            state <= ST_COL;
          end
        end
        ST_COL: begin
          col_r  <= clamp_unit(4 * ($signed(col_v) - 32'(psa_pkg::COL_THIRD)));
          col_g  <= clamp_unit(($signed(col_v) < 32'sd65536 - $signed(col_v)) ?
                               4 * $signed(col_v) : 4 * (32'sd65536 - $signed(col_v)));
          col_b  <= clamp_unit(4 * (32'sd32768 - $signed(col_v)));
          ic     <= xp - psa_pkg::coord_t'(psa_pkg::HALF_SPAN);
          i_end  <= xp + psa_pkg::coord_t'(psa_pkg::HALF_SPAN);
          jc     <= yp - psa_pkg::coord_t'(psa_pkg::HALF_SPAN);
          j0     <= yp - psa_pkg::coord_t'(psa_pkg::HALF_SPAN);
          j_end  <= yp + psa_pkg::coord_t'(psa_pkg::HALF_SPAN);
          axis_y <= 1'b0;
          state  <= ST_AXD;
        end
        // Axis falloff exponent
        ST_AXD: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(axis_ad), b: axis_ad};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            d2    <= ar_res[47:16];
            state <= ST_AXT;
          end
        end
        ST_AXT: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(d2), b: 40'(sharpness_sq)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            tq    <= ar_res[43:12];
            state <= ST_AXU;
          end
        end
        ST_AXU: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(tq),
                        b: 40'(psa_pkg::LOG2E_Q16)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend    <= 1'b0;
            eu      <= ar_res[46:16];
            exp_ret <= axis_y ? ST_GEY : ST_GEX;
            state   <= ST_EXP0;
          end
        end
        // exp2 subroutine: one table multiply per set fraction bit
        ST_EXP0: begin
          if (eu[30:16] >= 15'd23) begin
            eres  <= psa_pkg::EXP_CAP;
            state <= exp_ret;
          end else begin
            mant  <= 32'h4000_0000;
            step  <= 4'd0;
            state <= ST_EXPK;
          end
        end
        ST_EXPK: begin
          if (!eu[4'd15 - step]) begin
            if (step == 4'd15) begin
              state <= ST_EXPF;
            end else begin
              step <= step + 4'd1;
            end
          end else if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(mant),
                        b: 40'(psa_pkg::POW2_TAB[step])};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend <= 1'b0;
            mant <= ar_res[61:30];
            if (step == 4'd15) begin
              state <= ST_EXPF;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        ST_EXPF: begin
          eres  <= eshift[53:14];
          state <= exp_ret;
        end
        ST_GEX: begin
          ex     <= eres;
          axis_y <= 1'b1;
          state  <= ST_AXD;
        end
        ST_GEY: begin
          nrm   <= (ssum > 41'(psa_pkg::EXP_CAP)) ? psa_pkg::EXP_CAP : ssum[39:0];
          lb    <= 6'd39;
          maddr <= psa_pkg::addr_t'(ic) +
                   psa_pkg::addr_t'(psa_pkg::IMAGE_WIDTH) * psa_pkg::addr_t'(jc);
          state <= ST_LNRM;
        end
        // log2: normalize, then square and compare per fraction bit
        ST_LNRM: begin
          if (nrm[39]) begin
            mant  <= {1'b0, nrm[39:9]};
            frac  <= '0;
            step  <= 4'd15;
            state <= ST_LSQ;
          end else begin
            nrm <= {nrm[38:0], 1'b0};
            lb  <= lb - 6'd1;
          end
        end
        ST_LSQ: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(mant), b: 40'(mant)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend <= 1'b0;
            if (ar_res[61]) begin
              mant       <= {1'b0, ar_res[61:31]};
              frac[step] <= 1'b1;
            end else begin
              mant <= ar_res[61:30];
            end
            if (step == 4'd0) begin
              state <= ST_LFIN;
            end else begin
              step <= step - 4'd1;
            end
          end
        end
        ST_LFIN: begin
          eu      <= 31'(l3[22:2]);
          exp_ret <= ST_WDIV;
          state   <= ST_EXP0;
        end
        // Dot weight
        ST_WDIV: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_DIV, a: 56'({brightness, 16'd0}),
                        b: eres + 40'd65536};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend  <= 1'b0;
            wgt   <= ar_res[15:0];
            ch    <= 2'd0;
            state <= ST_CH;
          end
        end
        // Per-channel weighted add, saturating
        ST_CH: begin
          if (!pend) begin
            ar_ctl <= '{start: 1'b1, op: psa_pkg::ARITH_MUL, a: 56'(col_sel), b: 40'(wgt)};
            pend   <= 1'b1;
          end else if (ar_sts.done) begin
            pend <= 1'b0;
            case (ch)
              2'd0:    acc_r <= ch_sat;
              2'd1:    acc_g <= ch_sat;
              default: acc_b <= ch_sat;
            endcase
            if (ch == 2'd2) begin
              state <= ST_WR;
            end else begin
              ch <= ch + 2'd1;
            end
          end
        end
        // Write back and advance over the square
        ST_WR: begin
          if (jc + psa_pkg::coord_t'(1) != j_end) begin
            jc     <= jc + psa_pkg::coord_t'(1);
            axis_y <= 1'b1;
            state  <= ST_AXD;
          end else if (ic + psa_pkg::coord_t'(1) != i_end) begin
            ic     <= ic + psa_pkg::coord_t'(1);
            jc     <= j0;
            axis_y <= 1'b0;
            state  <= ST_AXD;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  psa_ram #(
    .WIDTH (psa_pkg::PIX_W),
    .DEPTH (psa_pkg::NPIX)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  psa_arith u_arith (
    .clk (clk),
    .rst (rst),
    .ctl (ar_ctl),
    .sts (ar_sts),
    .res (ar_res)
  );

  `PSA_ASSERT(a_read_result, clk, rst, (start && !busy && cmd == psa_pkg::CMD_READ) |-> ##3 result_valid)
  `PSA_ASSERT(a_result_from_read, clk, rst, result_valid |-> $past(state == ST_RD1))
  `PSA_ASSERT(a_no_issue_busy, clk, rst, ar_ctl.start |-> !ar_sts.busy)
  `PSA_ASSERT(a_idle_unit_free, clk, rst, !busy |-> (!ar_sts.busy && !ar_ctl.start))

endmodule

`default_nettype wire

// ===== rtl/psa_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/psa_arith.sv =====
// ============================================================================
// Shared arithmetic unit
// Registered 32x32 multiply, 40-bit restoring divide, 56-bit integer sqrt.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "particle_splat_accumulator_defines.svh"

module psa_arith (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire psa_pkg::arith_ctl_t  ctl,
  output psa_pkg::arith_sts_t       sts,
  output logic [63:0]               res
);

  logic        busy;
  logic        done;
  logic [1:0]  op_r;
  logic [5:0]  cnt;
  logic [39:0] quo;
  logic [40:0] rem;
  logic [39:0] den;
  logic [55:0] rad;
  logic [31:0] srem;
  logic [27:0] root;

  logic [63:0] prod;
  logic [40:0] rem_sh;
  logic        div_ge;
  logic [40:0] rem_next;
  logic [39:0] quo_next;
  logic [31:0] sr_sh;
  logic [31:0] trial;
  logic        sq_ge;
  logic [31:0] srem_next;
  logic [27:0] root_next;

  assign sts.busy = busy;
  assign sts.done = done;

  // Multiply, one divide step, one sqrt step
  always_comb begin
    prod      = ctl.a[31:0] * ctl.b[31:0];
    rem_sh    = {rem[39:0], quo[39]};
    div_ge    = rem_sh >= {1'b0, den};
    rem_next  = div_ge ? (rem_sh - {1'b0, den}) : rem_sh;
    quo_next  = {quo[38:0], div_ge};
    sr_sh     = {srem[29:0], rad[55:54]};
    trial     = {2'b00, root, 2'b01};
    sq_ge     = sr_sh >= trial;
    srem_next = sq_ge ? (sr_sh - trial) : sr_sh;
    root_next = {root[26:0], sq_ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        case (ctl.op) inside
          psa_pkg::ARITH_MUL: done <= 1'b1;
          psa_pkg::ARITH_DIV,
          psa_pkg::ARITH_SQRT: busy <= 1'b1;
          default: done <= 1'b1;
        endcase
      end else if (busy && cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r <= ctl.op;
      case (ctl.op)
        psa_pkg::ARITH_MUL: res <= prod;
        psa_pkg::ARITH_DIV: begin
          quo <= ctl.a[39:0];
          den <= ctl.b;
          rem <= '0;
          cnt <= 6'd40;
        end
        psa_pkg::ARITH_SQRT: begin
          rad  <= ctl.a;
          srem <= '0;
          root <= '0;
          cnt  <= 6'd28;
        end
        default: res <= '0;
      endcase
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (op_r == psa_pkg::ARITH_DIV) begin
        rem <= rem_next;
        quo <= quo_next;
        res <= 64'(quo_next);
      end else begin
        srem <= srem_next;
        root <= root_next;
        rad  <= {rad[53:0], 2'b00};
        res  <= 64'(root_next);
      end
    end
  end

  `PSA_ASSERT_NEXT(a_mul_one_cycle, clk, rst, ctl.start && ctl.op == psa_pkg::ARITH_MUL, sts.done)
  `PSA_ASSERT(a_busy_from_start, clk, rst, $rose(busy) |-> $past(ctl.start))

endmodule

`default_nettype wire
